// ----- hw/rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the binary min-heap queue
// Entry, transaction payload and memory request types, command and status
// codes, and the capacity of the heap store.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  // Heap geometry and field widths
  localparam int CAPACITY   = 256;
  localparam int TAG_BITS   = 16;
  localparam int KEY_BITS   = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  // child index 2*pos+2 needs two more bits than a position
  localparam int CHILD_BITS = ADDR_BITS + 2;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  typedef struct packed {
    logic                cmd;
    logic [TAG_BITS-1:0] item_tag;
    logic [KEY_BITS-1:0] priority_key;
  } in_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] removed_tag;
    logic                tag_valid;
    logic [1:0]          status;
    logic [CNT_BITS-1:0] entry_count;
  } out_t;

  // One write port and two read ports of the heap store
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    entry_t               wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr_a;
    logic [ADDR_BITS-1:0] raddr_b;
  } mem_req_t;

  function automatic out_t mk_out(logic [TAG_BITS-1:0] rtag, logic valid,
                                  logic [1:0] stat, logic [CNT_BITS-1:0] cnt);
    out_t o;
    o.removed_tag = rtag;
    o.tag_valid   = valid;
    o.status      = stat;
    o.entry_count = cnt;
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bmhq_mem.sv -----
// ----------------------------------------------------------------------------
// bmhq_mem: heap entry store
// Synchronous memory, one write port and two read ports with registered
// read data. No reset: entries are valid once written.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_mem
  import bmhq_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_a,
  output entry_t        rd_b
);

  entry_t mem [CAPACITY];
  entry_t rd_a_r;
  entry_t rd_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_a_r <= mem[req.raddr_a];
      rd_b_r <= mem[req.raddr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

// ----- hw/rtl/bmhq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmhq_ctrl: sift sequencer of the heap queue
// Holds the moving entry in a register and walks it up or down the heap,
// one level per cycle: each level compares the returned read data, writes
// the displaced entry back and issues the reads of the next level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire in_t    in_data,
  output logic        busy,
  output logic        out_strobe,
  output out_t        out_data,
  output mem_req_t    mem_req,
  input  wire entry_t rd_a,
  input  wire entry_t rd_b
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_UP   = 5'b00010,
    ST_ROOT = 5'b00100,
    ST_DOWN = 5'b01000,
    ST_PUT  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0]  pos_r, pos_nxt;
  logic [CHILD_BITS-1:0] idx_r, idx_nxt;   // parent (up) or left child (down)
  entry_t                cur_r, cur_nxt;
  logic [TAG_BITS-1:0]   rtag_r, rtag_nxt;
  logic                  rm_r, rm_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_r, out_nxt;

  // sift-down pick
  logic                  r_ok;
  logic                  take_r;
  logic                  gt_a;
  logic                  gt_b;
  logic                  swap_dn;
  entry_t                pick;
  logic [CHILD_BITS-1:0] pick_idx;
  logic [CHILD_BITS-1:0] next_left;
  logic [CHILD_BITS-1:0] next_right;
  logic [CHILD_BITS-1:0] cnt_ext;
  // sift-up parent
  logic [ADDR_BITS-1:0]  par;
  logic [ADDR_BITS-1:0] up_par;

  assign cnt_ext    = CHILD_BITS'(cnt_r);
  assign par        = idx_r[ADDR_BITS-1:0];
  assign up_par     = (par - ADDR_BITS'(1)) >> 1;

  // child compare: ties go left; key compares run in parallel
  assign r_ok       = (idx_r + CHILD_BITS'(1)) < cnt_ext;
  assign take_r     = r_ok && (rd_b.key < rd_a.key);
  assign gt_a       = cur_r.key > rd_a.key;
  assign gt_b       = cur_r.key > rd_b.key;
  assign swap_dn    = take_r ? gt_b : gt_a;
  assign pick       = take_r ? rd_b : rd_a;
  assign pick_idx   = idx_r + CHILD_BITS'(take_r);
  assign next_left  = CHILD_BITS'({pick_idx[ADDR_BITS-1:0], 1'b1});
  assign next_right = next_left + CHILD_BITS'(1);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    rtag_nxt      = rtag_r;
    rm_nxt        = rm_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.cmd == CMD_INSERT) begin
            if (cnt_r >= CNT_BITS'(CAPACITY)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out('0, 1'b0, STAT_FULL, cnt_r);
            end else begin
              cur_nxt.tag = in_data.item_tag;
              cur_nxt.key = in_data.priority_key;
              pos_nxt     = cnt_r[ADDR_BITS-1:0];
              cnt_nxt     = cnt_r + CNT_BITS'(1);
              rm_nxt      = 1'b0;
              if (cnt_r == '0) begin
                state_nxt = ST_PUT;
              end else begin
                idx_nxt         = CHILD_BITS'((cnt_r - CNT_BITS'(1)) >> 1);
                mem_req.re      = 1'b1;
                mem_req.raddr_a = ADDR_BITS'((cnt_r - CNT_BITS'(1)) >> 1);
                state_nxt       = ST_UP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out('0, 1'b0, STAT_EMPTY, '0);
            end else begin
              // fetch root and last entry together
              cnt_nxt         = cnt_r - CNT_BITS'(1);
              pos_nxt         = '0;
              rm_nxt          = 1'b1;
              mem_req.re      = 1'b1;
              mem_req.raddr_a = '0;
              mem_req.raddr_b = ADDR_BITS'(cnt_r - CNT_BITS'(1));
              state_nxt       = ST_ROOT;
            end
          end
        end
      end

      ST_UP: begin
        if (cur_r.key < rd_a.key) begin
          // parent moves down into the hole
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = rd_a;
          pos_nxt       = par;
          if (par == '0) begin
            state_nxt = ST_PUT;
          end else begin
            idx_nxt         = CHILD_BITS'(up_par);
            mem_req.re      = 1'b1;
            mem_req.raddr_a = up_par;
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = cur_r;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out('0, 1'b0, STAT_OK, cnt_r);
          state_nxt     = ST_IDLE;
        end
      end

      ST_ROOT: begin
        rtag_nxt = rd_a.tag;
        cur_nxt  = rd_b;
        if (cnt_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(rd_a.tag, 1'b1, STAT_OK, cnt_r);
          state_nxt     = ST_IDLE;
        end else if (cnt_r == CNT_BITS'(1)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = rd_b;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(rd_a.tag, 1'b1, STAT_OK, cnt_r);
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt         = CHILD_BITS'(1);
          mem_req.re      = 1'b1;
          mem_req.raddr_a = ADDR_BITS'(1);
          mem_req.raddr_b = ADDR_BITS'(2);
          state_nxt       = ST_DOWN;
        end
      end

      ST_DOWN: begin
        if (swap_dn) begin
          // smaller child moves up into the hole
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = pick;
          pos_nxt       = pick_idx[ADDR_BITS-1:0];
          if (next_left < cnt_ext) begin
            idx_nxt         = next_left;
            mem_req.re      = 1'b1;
            mem_req.raddr_a = next_left[ADDR_BITS-1:0];
            mem_req.raddr_b = next_right[ADDR_BITS-1:0];
          end else begin
            state_nxt = ST_PUT;
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = cur_r;
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(rtag_r, 1'b1, STAT_OK, cnt_r);
          state_nxt     = ST_IDLE;
        end
      end

      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r;
        mem_req.wdata = cur_r;
        out_valid_nxt = 1'b1;
        out_nxt       = rm_r ? mk_out(rtag_r, 1'b1, STAT_OK, cnt_r)
                             : mk_out('0, 1'b0, STAT_OK, cnt_r);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    idx_r  <= idx_nxt;
    cur_r  <= cur_nxt;
    rtag_r <= rtag_nxt;
    rm_r   <= rm_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/binary_min_heap_queue_top.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top: binary min-heap priority queue
// Insert appends a (tag, key) entry and sifts it up; remove returns the
// root's tag and sifts the last entry down from the root.
//
//   channel   ports                       transaction
//   input     start, busy, in_data        start && !busy at a rising edge
//   result    out_strobe, out_data        out_strobe high for one cycle
//
// Each level is one registered read of the heap store followed by a
// compare and write-back, so the store's read latency sets the pace.
// For a sift, busy stays high until the result is shown; full/empty
// errors never raise busy.
// Reset (rst_n low, synchronous) empties the heap; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue_top
  import bmhq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire in_t  in_data,
  output logic      busy,
  output logic      out_strobe,
  output out_t      out_data
);

  mem_req_t mem_req;
  entry_t   rd_a;
  entry_t   rd_b;

  // sift sequencer
  bmhq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .mem_req    (mem_req),
    .rd_a       (rd_a),
    .rd_b       (rd_b)
  );

  // heap entry store
  bmhq_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/bmhq_chk.sv -----
// ----------------------------------------------------------------------------
// bmhq_chk: port-level checks of the heap queue
// Watches the top level's ports and flags handshakes and results that
// break the queue's rules, then binds itself to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_chk
  import bmhq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire out_t out_data
);

  // an accepted transaction is either in work or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted transaction neither busy nor answered");

  // finishing a sift always shows a result
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  // a returned tag comes only with ok status
  a_tag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.tag_valid |-> out_data.status == STAT_OK)
    else $error("tag returned with error status");

  // remove from empty heap reports nothing
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status == STAT_EMPTY |->
      out_data.entry_count == '0 && !out_data.tag_valid &&
      out_data.removed_tag == '0)
    else $error("bad empty-heap result");

  // insert into full heap reports full count
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status == STAT_FULL |->
      out_data.entry_count == CNT_BITS'(CAPACITY))
    else $error("bad full-heap result");

endmodule

bind binary_min_heap_queue_top bmhq_chk u_chk (.*);

`default_nettype wire

// ----- tb/heap_queue_checker.sv -----
// ----------------------------------------------------------------------------
// heap_queue_checker: result checker for the binary min-heap queue
// Watches the command and result channels, keeps its own copy of the heap,
// predicts each result and compares it field by field with what the block
// returns.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_queue_checker
  import bmhq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic busy,
  input  wire in_t  in_data,
  input  wire logic out_strobe,
  input  wire out_t out_data,
  output int        fail_count,
  output int        pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow heap: tags and keys by slot, plus the entry count
  logic [TAG_BITS-1:0] shadow_tag [CAPACITY];
  logic [KEY_BITS-1:0] shadow_key [CAPACITY];
  int unsigned         shadow_fill;

  // Results predicted but not yet returned, oldest first
  out_t due_results [$];

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [TAG_BITS-1:0] t;
    logic [KEY_BITS-1:0] k;
    t = shadow_tag[a];
    k = shadow_key[a];
    shadow_tag[a] = shadow_tag[b];
    shadow_key[a] = shadow_key[b];
    shadow_tag[b] = t;
    shadow_key[b] = k;
  endfunction

  // Apply one command to the shadow heap and return the result it gives
  function automatic out_t apply_heap_op(in_t op);
    out_t        r;
    int unsigned pos;
    int unsigned up;
    int unsigned left;
    int unsigned right;
    int unsigned pick;
    bit          moving;
    r.removed_tag = '0;
    r.tag_valid   = 1'b0;
    r.status      = STAT_OK;
    if (op.cmd == CMD_INSERT) begin
      if (shadow_fill >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        pos = shadow_fill;
        shadow_tag[pos] = op.item_tag;
        shadow_key[pos] = op.priority_key;
        shadow_fill++;
        // climb while strictly smaller than the parent
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_key[pos] < shadow_key[up]) begin
            swap_slots(pos, up);
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else if (shadow_fill == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.removed_tag = shadow_tag[0];
      r.tag_valid   = 1'b1;
      shadow_fill--;
      shadow_tag[0] = shadow_tag[shadow_fill];
      shadow_key[0] = shadow_key[shadow_fill];
      // descend; right child only when strictly smaller, a lone left child
      // is still compared
      pos = 0;
      moving = 1'b1;
      while (moving) begin
        left  = 2 * pos + 1;
        right = left + 1;
        if (left >= shadow_fill) begin
          moving = 1'b0;
        end else begin
          pick = left;
          if (right < shadow_fill && shadow_key[right] < shadow_key[left])
            pick = right;
          if (shadow_key[pos] > shadow_key[pick]) begin
            swap_slots(pos, pick);
            pos = pick;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end
    r.entry_count = CNT_BITS'(shadow_fill);
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Compare returned results first, then record the new transaction
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      due_results.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("removed_tag", want.removed_tag, out_data.removed_tag);
          check_field("tag_valid", want.tag_valid, out_data.tag_valid);
          check_field("status", want.status, out_data.status);
          check_field("entry_count", want.entry_count, out_data.entry_count);
        end
      end
      if (start && busy === 1'b0)
        due_results.push_back(apply_heap_op(in_data));
    end
    pending = due_results.size();
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the binary min-heap queue
// Drives directed and random insert/remove transactions with random sender
// gaps, fills the heap past capacity and drains it past empty, and lets the
// checker module predict and compare every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import bmhq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 660;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE      = 30;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  in_t  in_data;
  logic busy;
  logic out_strobe;
  out_t out_data;
  int   fail_count;
  int   pending;

  // stimulus-side bookkeeping: percent of idle cycles, rough heap occupancy
  int   idle_pct;
  int   heap_level;

  always #6 clk = ~clk;

  binary_min_heap_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  heap_queue_checker heap_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Keys: extremes, a narrow band for ties, or anything
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_BITS'($urandom_range(0, 15));
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  function automatic in_t make_op(logic cmd, logic [TAG_BITS-1:0] tag,
                                  logic [KEY_BITS-1:0] key);
    in_t op;
    op.cmd          = cmd;
    op.item_tag     = tag;
    op.priority_key = key;
    return op;
  endfunction

  // One transaction: random gap, then hold start until the block takes it
  task automatic issue(in_t op);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= in_t'({$urandom, $urandom});
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= op;
    do @(posedge clk); while (busy !== 1'b0);
    if (op.cmd == CMD_INSERT) begin
      if (heap_level < CAPACITY) heap_level++;
    end else if (heap_level > 0) begin
      heap_level--;
    end
  endtask

  // Random commands; remove fields carry random don't-care content
  task automatic random_burst(int count, int insert_pct);
    logic cmd;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      issue(make_op(cmd, TAG_BITS'($urandom), pick_key()));
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Watchdog: too long without any transaction on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && busy === 1'b0) || out_strobe === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int sent;
    int count;
    int pct;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    idle_pct   = 9;
    heap_level = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty remove, extreme fields, key ties at the root
    issue(make_op(CMD_REMOVE, '0, '0));
    issue(make_op(CMD_INSERT, '1, '1));
    issue(make_op(CMD_INSERT, '0, '0));
    issue(make_op(CMD_INSERT, 16'h1234, '0));
    repeat (3) issue(make_op(CMD_REMOVE, '1, '1));
    // lone left child: last entry moved to root must still swap with it
    issue(make_op(CMD_INSERT, 16'h0001, 32'd5));
    issue(make_op(CMD_INSERT, 16'h0002, 32'd7));
    issue(make_op(CMD_INSERT, 16'h0003, 32'd10));
    repeat (4) issue(make_op(CMD_REMOVE, '0, '0));
    // equal children: the left one wins
    issue(make_op(CMD_INSERT, 16'h00a0, 32'd1));
    issue(make_op(CMD_INSERT, 16'h00b0, 32'd4));
    issue(make_op(CMD_INSERT, 16'h00c0, 32'd4));
    issue(make_op(CMD_INSERT, 16'h00d0, 32'd9));
    repeat (4) issue(make_op(CMD_REMOVE, '0, '0));

    // Random phases: light sender gaps, heavy gaps, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 9 : (phase == 1) ? 83 : 0;
      hold_until_drained();
      sent = 0;
      if (phase != 1) begin
        // fill past capacity, then drain past empty
        count = CAPACITY - heap_level + 3;
        random_burst(count, 100);
        sent += count;
        count = heap_level + 3;
        random_burst(count, 0);
        sent += count;
      end
      while (sent < PHASE_ITEMS) begin
        count = $urandom_range(10, 80);
        case ($urandom_range(0, 2))
          0:       pct = 80;
          1:       pct = 20;
          default: pct = 50;
        endcase
        random_burst(count, pct);
        sent += count;
      end
    end

    // Wait out the last results, then give the verdict
    hold_until_drained();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_mem.sv
hw/rtl/bmhq_ctrl.sv
hw/rtl/binary_min_heap_queue_top.sv
hw/rtl/bmhq_chk.sv
tb/heap_queue_checker.sv
tb/testbench.sv
